// ===== rtl/tpwm_pkg.sv =====
// Shared types, constants and helper functions for the thruster PWM block.
// Depends on nothing; every other file of the block refers to it by scoped names.
package tpwm_pkg;

  localparam int Channels     = 8;
  localparam int SampleWidth  = 16;
  localparam int FracBits     = SampleWidth - 1;
  localparam int PeriodWidth  = 16;
  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 16;
  localparam int QueueDepth   = 4;
  localparam int ThWidth      = SampleWidth + PeriodWidth;
  localparam int ProdWidth    = 2 * SampleWidth + 1;

  localparam logic [PeriodWidth-1:0] PeriodReset   = PeriodWidth'(100);
  localparam logic [FracBits-1:0]    DeadbandReset = FracBits'(1638);
  localparam logic [FracBits-1:0]    GainReset     = FracBits'(28508);

  localparam logic [CfgIdxWidth-1:0] RegPwmPeriod  = CfgIdxWidth'(0);
  localparam logic [CfgIdxWidth-1:0] RegDeadband   = CfgIdxWidth'(1);
  localparam logic [CfgIdxWidth-1:0] RegThrustGain = CfgIdxWidth'(2);

  // Which of the four distinct duties feeds a channel.
  localparam logic [2:0] SrcOff    = 3'd0;
  localparam logic [2:0] SrcLinFwd = 3'd1;
  localparam logic [2:0] SrcLinRev = 3'd2;
  localparam logic [2:0] SrcAngFwd = 3'd3;
  localparam logic [2:0] SrcAngRev = 3'd4;

  localparam logic signed [ProdWidth:0] RoundBias =
    {{(ProdWidth + 1 - FracBits){1'b0}}, 1'b1, {(FracBits - 1){1'b0}}};
  localparam logic signed [ProdWidth:0] SatMax =
    {{(ProdWidth + 1 - FracBits){1'b0}}, {FracBits{1'b1}}};
  localparam logic signed [ProdWidth:0] SatMin =
    {{(ProdWidth + 1 - FracBits){1'b1}}, {FracBits{1'b0}}};

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic [SampleWidth-1:0]        duty_t;

  // One classified beat as it travels from the front to the back.
  typedef struct packed {
    logic  is_cmd;
    duty_t lin_fwd;
    duty_t lin_rev;
    duty_t ang_fwd;
    duty_t ang_rev;
  } entry_t;

  function automatic logic [2:0] duty_src(input int ch);
    logic [2:0] src;
    case (ch)
      0, 4:    src = SrcLinFwd;
      1, 5:    src = SrcLinRev;
      2:       src = SrcAngRev;
      3:       src = SrcAngFwd;
      default: src = SrcOff;
    endcase
    return src;
  endfunction

  // Round half up on the Q3.30 product, then saturate to Q1.15.
  function automatic sample_t round_sat(input logic signed [ProdWidth-1:0] p);
    logic signed [ProdWidth:0] sum;
    logic signed [ProdWidth:0] q;
    sum = $signed({p[ProdWidth-1], p}) + RoundBias;
    q   = sum >>> FracBits;
    if (q > SatMax) begin
      q = SatMax;
    end else if (q < SatMin) begin
      q = SatMin;
    end
    return q[SampleWidth-1:0];
  endfunction

endpackage

// ===== rtl/tpwm_if.sv =====
// Valid/ready channel interfaces for the request and response streams.
// Depends on tpwm_pkg for field widths.
interface tpwm_req_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  tpwm_pkg::sample_t        linear_x;
  tpwm_pkg::sample_t        angular_z;

  modport source (output valid, req_type, linear_x, angular_z, input ready);
  modport sink   (input valid, req_type, linear_x, angular_z, output ready);
endinterface

interface tpwm_rsp_if #(
  parameter int Channels = tpwm_pkg::Channels
);
  logic                     valid;
  logic                     ready;
  logic [Channels-1:0]      thruster_lines;
  tpwm_pkg::sample_t        force_pair_a;
  tpwm_pkg::sample_t        force_pair_b;
  tpwm_pkg::sample_t        force_pair_c;

  modport source (output valid, thruster_lines, force_pair_a, force_pair_b, force_pair_c,
                  input ready);
  modport sink   (input valid, thruster_lines, force_pair_a, force_pair_b, force_pair_c,
                  output ready);
endinterface

// ===== rtl/tpwm_front.sv =====
// Front end: accepts request beats and splits velocity commands into duties.
// Depends on tpwm_pkg and tpwm_req_if.
module tpwm_front (
  tpwm_req_if.sink                   req,
  input  logic [tpwm_pkg::FracBits-1:0] deadband_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output tpwm_pkg::entry_t           push_entry_o
);

  localparam int W = tpwm_pkg::SampleWidth;

  logic signed [W:0] db_pos;
  logic signed [W:0] db_neg;
  logic signed [W:0] lin_x;
  logic signed [W:0] ang_x;
  logic signed [W:0] lin_neg;
  logic signed [W:0] ang_neg;

  assign db_pos  = $signed({{(W + 1 - tpwm_pkg::FracBits){1'b0}}, deadband_i});
  assign db_neg  = -db_pos;
  assign lin_x   = $signed({req.linear_x[W-1], req.linear_x});
  assign ang_x   = $signed({req.angular_z[W-1], req.angular_z});
  assign lin_neg = -lin_x;
  assign ang_neg = -ang_x;

  always_comb begin
    push_entry_o         = '0;
    push_entry_o.is_cmd  = req.req_type;
    // A value at or above the deadband drives forward, at or below its negative drives reverse.
    if (lin_x >= db_pos) begin
      push_entry_o.lin_fwd = lin_x[W-1:0];
    end else if (lin_x <= db_neg) begin
      push_entry_o.lin_rev = lin_neg[W-1:0];
    end
    if (ang_x >= db_pos) begin
      push_entry_o.ang_fwd = ang_x[W-1:0];
    end else if (ang_x <= db_neg) begin
      push_entry_o.ang_rev = ang_neg[W-1:0];
    end
  end

  assign push_valid_o = req.valid;
  assign req.ready    = push_ready_i;

endmodule

// ===== rtl/tpwm_queue.sv =====
// Short register queue that decouples the front end from the back end.
// Depends on tpwm_pkg for the entry type.
module tpwm_queue #(
  parameter int Depth = tpwm_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  tpwm_pkg::entry_t push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output tpwm_pkg::entry_t pop_entry_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tpwm_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    case ({push, pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== rtl/tpwm_back.sv =====
// Back end: holds duties, counter, line levels and force estimates, and
// executes tick and command beats in two stages. Depends on tpwm_pkg, tpwm_rsp_if.
module tpwm_back #(
  parameter int Channels = tpwm_pkg::Channels
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pop_valid_i,
  output logic                            pop_ready_o,
  input  tpwm_pkg::entry_t                pop_entry_i,
  input  logic [tpwm_pkg::PeriodWidth-1:0] period_i,
  input  logic [tpwm_pkg::FracBits-1:0]   gain_i,
  tpwm_rsp_if.source                      rsp
);

  localparam int W  = tpwm_pkg::SampleWidth;
  localparam int PW = tpwm_pkg::PeriodWidth;
  localparam int TW = tpwm_pkg::ThWidth;
  localparam int MW = tpwm_pkg::ProdWidth;

  // Duty state: the four distinct magnitudes that feed the channels.
  tpwm_pkg::duty_t duty_lf_q, duty_lr_q, duty_af_q, duty_ar_q;

  // Stage one registers.
  logic                 s1_valid_q;
  logic                 s1_cmd_q;
  logic signed [MW-1:0] s1_plin_q, s1_pang_q;
  logic [TW-1:0]        s1_th_lf_q, s1_th_lr_q, s1_th_af_q, s1_th_ar_q;

  // Architectural state; the lines and forces are also the response payload.
  logic [PW-1:0]        counter_q;
  logic [Channels-1:0]  lines_q;
  tpwm_pkg::sample_t    force_a_q, force_b_q, force_c_q;
  logic                 out_valid_q;

  logic                 adv;
  logic                 pop;
  logic signed [W:0]    diff_lin, diff_ang;
  logic signed [W:0]    gain_x;
  logic signed [MW-1:0] plin, pang;
  logic [TW-1:0]        lhs;
  logic [Channels-1:0]  lines_d;
  logic [PW-1:0]        cnt_inc, cnt_next;

  // The whole back end moves when the response register is free or being drained.
  assign adv         = !out_valid_q || rsp.ready;
  assign pop_ready_o = adv;
  assign pop         = pop_valid_i && adv;

  assign diff_lin = $signed({1'b0, pop_entry_i.lin_fwd}) - $signed({1'b0, pop_entry_i.lin_rev});
  assign diff_ang = $signed({1'b0, pop_entry_i.ang_fwd}) - $signed({1'b0, pop_entry_i.ang_rev});
  assign gain_x   = $signed({{(W + 1 - tpwm_pkg::FracBits){1'b0}}, gain_i});
  assign plin     = MW'(diff_lin) * MW'(gain_x);
  assign pang     = MW'(diff_ang) * MW'(gain_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_lf_q <= '0;
      duty_lr_q <= '0;
      duty_af_q <= '0;
      duty_ar_q <= '0;
    end else if (pop && pop_entry_i.is_cmd) begin
      duty_lf_q <= pop_entry_i.lin_fwd;
      duty_lr_q <= pop_entry_i.lin_rev;
      duty_af_q <= pop_entry_i.ang_fwd;
      duty_ar_q <= pop_entry_i.ang_rev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= pop_valid_i;
    end
  end

  // Tick thresholds use the duty registers, which already hold any command popped earlier.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q   <= pop_entry_i.is_cmd;
      s1_plin_q  <= plin;
      s1_pang_q  <= pang;
      s1_th_lf_q <= TW'(duty_lf_q) * TW'(period_i);
      s1_th_lr_q <= TW'(duty_lr_q) * TW'(period_i);
      s1_th_af_q <= TW'(duty_af_q) * TW'(period_i);
      s1_th_ar_q <= TW'(duty_ar_q) * TW'(period_i);
    end
  end

  assign lhs = TW'({counter_q, {tpwm_pkg::FracBits{1'b0}}});

  always_comb begin
    for (int ch = 0; ch < Channels; ch++) begin
      case (tpwm_pkg::duty_src(ch))
        tpwm_pkg::SrcLinFwd: lines_d[ch] = lhs < s1_th_lf_q;
        tpwm_pkg::SrcLinRev: lines_d[ch] = lhs < s1_th_lr_q;
        tpwm_pkg::SrcAngFwd: lines_d[ch] = lhs < s1_th_af_q;
        tpwm_pkg::SrcAngRev: lines_d[ch] = lhs < s1_th_ar_q;
        default:             lines_d[ch] = 1'b0;
      endcase
    end
  end

  // The counter wraps back to one on overflow or on reaching the period.
  assign cnt_inc  = counter_q + PW'(1);
  assign cnt_next = (cnt_inc == '0 || cnt_inc >= period_i) ? PW'(1) : cnt_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q   <= PW'(1);
      lines_q     <= '0;
      force_a_q   <= '0;
      force_b_q   <= '0;
      force_c_q   <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        if (s1_cmd_q) begin
          force_a_q <= tpwm_pkg::round_sat(s1_plin_q);
          force_b_q <= tpwm_pkg::round_sat(s1_pang_q);
          force_c_q <= tpwm_pkg::round_sat(-s1_plin_q);
        end else begin
          lines_q   <= lines_d;
          counter_q <= cnt_next;
        end
      end
    end
  end

  assign rsp.valid          = out_valid_q;
  assign rsp.thruster_lines = lines_q;
  assign rsp.force_pair_a   = force_a_q;
  assign rsp.force_pair_b   = force_b_q;
  assign rsp.force_pair_c   = force_c_q;

endmodule

// ===== rtl/thruster_pwm_with_deadband.sv =====
// Top level of the thruster PWM block: configuration registers and the
// front, queue and back instances. Depends on tpwm_pkg, tpwm_if, tpwm_front/queue/back.
//
//   channel  direction  fields
//   req      in         req_type, linear_x, angular_z
//   rsp      out        thruster_lines, force_pair_a, force_pair_b, force_pair_c
//   cfg      in         cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One beat per cycle is sustained while responses are taken; a beat's response is valid
// once it has passed the queue write at the accepting edge, then the multiply stage, then
// the state update into the response register.
// Throughput is set by the back end's two registered stages, which advance together.
// Reset clears the duties, counter (to one), lines, forces and all valid state.
// A stalled response stalls the back end; the four-entry queue keeps taking beats until full.
module thruster_pwm_with_deadband (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tpwm_req_if.sink                          req,
  tpwm_rsp_if.source                        rsp,
  input  logic                              cfg_we_i,
  input  logic [tpwm_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [tpwm_pkg::CfgDataWidth-1:0] cfg_data_i
);

  logic [tpwm_pkg::PeriodWidth-1:0] period_q;
  logic [tpwm_pkg::FracBits-1:0]    deadband_q;
  logic [tpwm_pkg::FracBits-1:0]    gain_q;

  logic             push_valid, push_ready;
  tpwm_pkg::entry_t push_entry;
  logic             pop_valid, pop_ready;
  tpwm_pkg::entry_t pop_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= tpwm_pkg::PeriodReset;
      deadband_q <= tpwm_pkg::DeadbandReset;
      gain_q     <= tpwm_pkg::GainReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tpwm_pkg::RegPwmPeriod:  period_q   <= cfg_data_i[tpwm_pkg::PeriodWidth-1:0];
        tpwm_pkg::RegDeadband:   deadband_q <= cfg_data_i[tpwm_pkg::FracBits-1:0];
        tpwm_pkg::RegThrustGain: gain_q     <= cfg_data_i[tpwm_pkg::FracBits-1:0];
        default: ;
      endcase
    end
  end

  tpwm_front u_front (
    .req          (req),
    .deadband_i   (deadband_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  tpwm_queue #(
    .Depth (tpwm_pkg::QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  tpwm_back #(
    .Channels (tpwm_pkg::Channels)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .period_i    (period_q),
    .gain_i      (gain_q),
    .rsp         (rsp)
  );

endmodule

// ===== rtl/tpwm_checker.sv =====
// Port-level checks on the response stream of the thruster PWM block, and the
// bind that attaches them to the top level. Depends on tpwm_pkg.
module tpwm_checker #(
  parameter int Channels = tpwm_pkg::Channels
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [Channels-1:0] lines_i,
  input tpwm_pkg::sample_t   fa_i,
  input tpwm_pkg::sample_t   fb_i,
  input tpwm_pkg::sample_t   fc_i
);

  logic signed [tpwm_pkg::SampleWidth:0] fsum;

  // The mirrored pair estimates differ only by rounding of an exact half.
  assign fsum = $signed({fa_i[tpwm_pkg::SampleWidth-1], fa_i})
              + $signed({fc_i[tpwm_pkg::SampleWidth-1], fc_i});

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(lines_i)
      && $stable(fa_i) && $stable(fb_i) && $stable(fc_i))
    else $error("response beat changed while stalled");

  a_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> lines_i[0] == lines_i[4] && lines_i[1] == lines_i[5])
    else $error("linear channel pairs disagree");

  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(lines_i[0] && lines_i[1]) && !(lines_i[2] && lines_i[3]))
    else $error("forward and reverse lines both on");

  a_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> lines_i[Channels-1:6] == '0)
    else $error("unused channel line driven");

  a_force_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> fsum == '0 || fsum == 1)
    else $error("pair a and pair c estimates are not mirrored");

endmodule

bind thruster_pwm_with_deadband tpwm_checker #(
  .Channels (tpwm_pkg::Channels)
) u_tpwm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready),
  .lines_i     (rsp.thruster_lines),
  .fa_i        (rsp.force_pair_a),
  .fb_i        (rsp.force_pair_b),
  .fc_i        (rsp.force_pair_c)
);
